// ===== sv/mhts_pkg.sv =====
// ----------------------------------------------------------------------------
// mhts_pkg
// shared types and codes of the min-heap timer scheduler
// ----------------------------------------------------------------------------
package mhts_pkg;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STOP  = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_EXPIRY = 1'b1;

	localparam logic REG_CAPACITY = 1'b0;
	localparam logic REG_REPEAT   = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE,
		S_START_RM,
		S_START_SET,
		S_STOP_RM,
		S_TICK_CHK,
		S_TICK_RM,
		S_TICK_RE,
		S_RM_BEGIN,
		S_SINK_A,
		S_SINK_B,
		S_RISE_BEGIN,
		S_RISE_A,
		S_RISE_B,
		S_RISE_END,
		S_INS_BEGIN,
		S_EMIT
	} state_t;

endpackage

// ===== sv/min_heap_timer_scheduler.sv =====
// ----------------------------------------------------------------------------
// min_heap_timer_scheduler
// binary min-heap of timers ordered by deadline, with an internal tick clock
// ----------------------------------------------------------------------------
// a start or stop strobes its status right after the sequencer ends, also for a
// bad parameter; a removal that leaves a hole fills it with the last slot and
// sifts it level by level; one shared deadline comparator
// a tick checks the top deadline against the clock; each expiry is removed and,
// if its repeat bit is set, re-armed while the heap has room; busy drops as the last result strobes
// the receiver cannot stall; reset clears the clock, count, slot map and tables
module min_heap_timer_scheduler import mhts_pkg::*; #(
	parameter int NUM_TIMERS = 16,
	parameter int TIME_BITS  = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [3:0]  timer_id,
	input  logic [31:0] interval,
	output logic        valid,
	output logic        kind,
	output logic [3:0]  fired_id,
	output logic [1:0]  status,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW = $clog2(NUM_TIMERS);        // id / position
	localparam int CW = $clog2(NUM_TIMERS + 1);    // count
	localparam logic [CW-1:0] NT = CW'(NUM_TIMERS);
	localparam logic [4:0] MAXRES = 5'd16;

	// configuration
	logic [4:0]  capacity_q;
	logic [15:0] repeat_mask_q;
	logic        wr;
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite && pready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q    <= 5'd16;
			repeat_mask_q <= '0;
		end else if (wr && paddr[2] == REG_CAPACITY && paddr[1:0] == 2'b00) begin
			capacity_q <= pwdata[4:0];
		end else if (wr && paddr[2] == REG_REPEAT && paddr[1:0] == 2'b00) begin
			repeat_mask_q <= pwdata[15:0];
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_CAPACITY) prdata[4:0] = capacity_q;
		else prdata[15:0] = repeat_mask_q;
	end

	// effective capacity, clipped to the heap size
	logic [CW-1:0] cap_eff;
	assign cap_eff = (32'(capacity_q) > 32'(NUM_TIMERS)) ? NT : CW'(capacity_q);

	// storage: heap slots and per-timer tables live in flops (small, fixed)
	logic [IW-1:0]        heap_q   [NUM_TIMERS];
	logic [TIME_BITS-1:0] dl_q     [NUM_TIMERS];
	logic [31:0]          per_q    [NUM_TIMERS];
	logic [CW-1:0]        slot_q   [NUM_TIMERS];
	logic [TIME_BITS-1:0] now_q;
	logic [CW-1:0]        cnt_q;

	state_t state_q, state_d, ret_q;
	logic [1:0]    op_q;
	logic [IW-1:0] id_q;       // timer being moved
	logic [3:0]    tid_q;      // timer the item concerns, or the last expired one
	logic [31:0]   ivl_q;
	logic [CW-1:0] pos_q;      // hole position
	logic [CW-1:0] ch_q;       // chosen child
	logic [4:0]    nres_q;
	logic [1:0]    st_q;
	logic          bad_q;
	logic          pend_q;     // an expiry waits for the next due check

	// shared compare unit: a < b on deadlines, or the clock against a deadline
	logic [TIME_BITS-1:0] cmp_a, cmp_b;
	logic                 lt;
	assign lt = cmp_a < cmp_b;

	logic [CW:0] lchild;
	assign lchild = {pos_q, 1'b1};
	logic [CW-1:0] par;
	assign par = (pos_q - CW'(1)) >> 1;

	logic [IW-1:0] tid_ix;
	assign tid_ix = IW'(tid_q);
	logic [IW-1:0] top_id;
	assign top_id = heap_q[0];

	assign busy = (state_q != S_IDLE);

	// the top of the heap is due and the result budget is not spent
	logic due;
	assign due = (nres_q < MAXRES) && (cnt_q != '0) && !lt;

	// removal: armed timers leave the heap, a hole is filled by the last slot
	logic armed_here, hole;
	assign armed_here = slot_q[id_q] != '0 && cnt_q != '0 &&
		(slot_q[id_q] - CW'(1)) < cnt_q;
	assign hole = armed_here && ((slot_q[id_q] - CW'(1)) != cnt_q - CW'(1));

	// compare operands for the current step
	always_comb begin
		cmp_a = dl_q[id_q];
		cmp_b = dl_q[id_q];
		case (state_q)
			S_TICK_CHK: begin
				cmp_a = now_q;
				cmp_b = dl_q[top_id];
			end
			S_SINK_A: begin
				cmp_a = dl_q[heap_q[IW'(lchild + (CW+1)'(1))]];
				cmp_b = dl_q[heap_q[IW'(lchild)]];
			end
			S_SINK_B: begin
				cmp_a = dl_q[heap_q[IW'(ch_q)]];
				cmp_b = dl_q[id_q];
			end
			S_RISE_B: begin
				cmp_a = dl_q[id_q];
				cmp_b = dl_q[heap_q[IW'(par)]];
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (start) begin
				case (opcode)
					OP_START: state_d = S_START_RM;
					OP_STOP:  state_d = S_STOP_RM;
					OP_TICK:  state_d = S_TICK_CHK;
					default:  state_d = S_IDLE;
				endcase
			end
			S_START_RM, S_STOP_RM: state_d = bad_q ? S_EMIT : S_RM_BEGIN;
			S_START_SET: state_d = (cnt_q >= cap_eff) ? S_EMIT : S_INS_BEGIN;
			S_TICK_CHK: state_d = due ? S_TICK_RM : S_IDLE;
			S_TICK_RM: state_d = S_RM_BEGIN;
			S_TICK_RE: state_d = (repeat_mask_q[tid_q] && cnt_q < cap_eff) ?
				S_INS_BEGIN : S_TICK_CHK;
			S_RM_BEGIN: state_d = hole ? S_SINK_A : ret_q;
			S_SINK_A: state_d = (lchild >= {1'b0, cnt_q}) ? S_RISE_A : S_SINK_B;
			S_SINK_B: state_d = lt ? S_SINK_A : S_RISE_A;
			S_RISE_A: state_d = (pos_q == '0) ? S_RISE_END : S_RISE_B;
			S_RISE_B: state_d = lt ? S_RISE_A : S_RISE_END;
			S_RISE_END: state_d = ret_q;
			S_INS_BEGIN: state_d = S_RISE_A;
			S_EMIT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			op_q    <= '0;
			id_q    <= '0;
			tid_q   <= '0;
			ivl_q   <= '0;
			pos_q   <= '0;
			ch_q    <= '0;
			nres_q  <= '0;
			st_q    <= ST_OK;
			bad_q   <= 1'b0;
			pend_q  <= 1'b0;
			now_q   <= '0;
			cnt_q   <= '0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				heap_q[i] <= '0;
				dl_q[i]   <= '0;
				per_q[i]  <= '0;
				slot_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: if (start && opcode != OP_NONE) begin
					op_q   <= opcode;
					tid_q  <= timer_id;
					ivl_q  <= interval;
					nres_q <= '0;
					st_q   <= ST_OK;
					pend_q <= 1'b0;
					bad_q  <= (opcode == OP_START && interval == '0) ||
						(32'(timer_id) >= 32'(NUM_TIMERS));
					if (opcode == OP_TICK) now_q <= now_q + TIME_BITS'(1);
				end
				S_START_RM, S_STOP_RM: begin
					id_q <= tid_ix;
					if (bad_q) st_q <= ST_BAD;
					ret_q <= (state_q == S_START_RM) ? S_START_SET : S_EMIT;
				end
				S_START_SET: begin
					per_q[tid_ix] <= ivl_q;
					dl_q[tid_ix]  <= now_q + TIME_BITS'(ivl_q);
					if (cnt_q >= cap_eff) st_q <= ST_FULL;
				end
				S_TICK_CHK: if (pend_q) pend_q <= 1'b0;
				S_TICK_RM: begin
					id_q   <= top_id;
					tid_q  <= 4'(top_id);
					ret_q  <= S_TICK_RE;
					nres_q <= nres_q + 5'd1;
				end
				S_TICK_RE: begin
					pend_q <= 1'b1;
					// deadline moves on even when the heap has no room
					if (repeat_mask_q[tid_q])
						dl_q[tid_ix] <= dl_q[tid_ix] + TIME_BITS'(per_q[tid_ix]);
				end
				S_RM_BEGIN: if (slot_q[id_q] != '0 && cnt_q != '0) begin
					slot_q[id_q] <= '0;
					if (armed_here) begin
						cnt_q <= cnt_q - CW'(1);
						pos_q <= slot_q[id_q] - CW'(1);
						// last element fills the hole and sifts
						id_q  <= heap_q[IW'(cnt_q - CW'(1))];
					end
				end
				S_SINK_A: ch_q <= (((lchild + (CW+1)'(1)) < {1'b0, cnt_q}) && lt) ?
					CW'(lchild + (CW+1)'(1)) : CW'(lchild);
				S_SINK_B: if (lt) begin
					heap_q[IW'(pos_q)] <= heap_q[IW'(ch_q)];
					slot_q[heap_q[IW'(ch_q)]] <= pos_q + CW'(1);
					pos_q <= ch_q;
				end
				S_RISE_B: if (lt) begin
					heap_q[IW'(pos_q)] <= heap_q[IW'(par)];
					slot_q[heap_q[IW'(par)]] <= pos_q + CW'(1);
					pos_q <= par;
				end
				S_RISE_END: begin
					heap_q[IW'(pos_q)] <= id_q;
					slot_q[id_q] <= pos_q + CW'(1);
				end
				S_INS_BEGIN: begin
					pos_q <= cnt_q;
					cnt_q <= cnt_q + CW'(1);
					id_q  <= tid_ix;
					ret_q <= (op_q == OP_TICK) ? S_TICK_CHK : S_EMIT;
				end
				default: ;
			endcase
		end
	end

	// results: a status at the end of a start or stop; an expiry once the
	// following due check tells whether it is the last one of the tick
	logic emit_now;
	assign emit_now = (state_q == S_EMIT) || (state_q == S_TICK_CHK && pend_q);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid    <= 1'b0;
			kind     <= KIND_STATUS;
			fired_id <= '0;
			status   <= ST_OK;
			last     <= 1'b0;
		end else begin
			valid <= emit_now;
			if (emit_now) begin
				kind     <= (state_q == S_TICK_CHK) ? KIND_EXPIRY : KIND_STATUS;
				fired_id <= tid_q;
				status   <= (state_q == S_TICK_CHK) ? ST_OK : st_q;
				last     <= (state_q == S_TICK_CHK) ? !due : 1'b1;
			end
		end
	end

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && kind == KIND_STATUS) |-> last);
	a_expiry_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && kind == KIND_EXPIRY) |-> status == ST_OK);
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last) |-> !busy);
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NT);

endmodule
